[src/ssbb_pkg.sv]
package ssbb_pkg;

  // request kinds carried in s_axis_tuser
  typedef enum logic [1:0] {
    REQ_CS    = 2'd0,
    REQ_EDGE  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  localparam int unsigned GreetLen = 23;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned ByteW    = 8;
  localparam logic [2:0]  LastBit  = 3'd7;

  // power-up transmit contents: "Response from SPI Slave"
  localparam logic [7:0] GREETING [GreetLen] = '{
    8'h52, 8'h65, 8'h73, 8'h70, 8'h6f, 8'h6e, 8'h73, 8'h65,
    8'h20, 8'h66, 8'h72, 8'h6f, 8'h6d, 8'h20, 8'h53, 8'h50,
    8'h49, 8'h20, 8'h53, 8'h6c, 8'h61, 8'h76, 8'h65
  };

  // greeting byte at a position, zero padded
  function automatic logic [7:0] tx_init(input int unsigned idx);
    logic [7:0] val;
    val = 8'h00;
    if (idx < GreetLen) begin
      val = GREETING[idx];
    end
    return val;
  endfunction

  // one result word
  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             data_ready;
    logic             busy_res;
    logic [SlotW-1:0] byte_pos;
    logic [ByteW-1:0] rx_byte;
    logic             miso_val;
    logic             byte_done;
  } result_t;

endpackage

[src/spi_slave_byte_buffer_core.sv]
// SPI slave shift register with receive and transmit byte stores, MSB first.
// Each input word is one event: a chip select change, a falling SPI clock edge
// (MOSI sampled, MISO driven from the transmit store), a transmit store write
// or a receive store read. Every word yields exactly one result word. A word
// is taken when the output register is free or its word leaves. Its whole
// effect is computed combinationally from the block state and lands in a single
// output register, so the throughput is one word per clock while results drain.
// The stores are flip-flop arrays of min(BUFFER_BYTES, 32) bytes, the reach of
// the 5-bit slot field; they are loaded at reset (receive all zero, transmit
// with "Response from SPI Slave"), so there is no clearing pass. On the input,
// tuser carries the request kind and tlast the clear-ready flag of a read.
module spi_slave_byte_buffer_core #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cs_level[0], mosi_val[1], slot[6:2], wdata[14:7], zero[15]
  input  logic [15:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // clear_ready
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // miso_val[0], rx_byte[8:1], byte_pos[13:9], busy_res[14], data_ready[15],
  // read_data[23:16]
  output logic [23:0] m_axis_tdata_o,
  // byte_done[0]
  output logic        m_axis_tuser_o
);
  import ssbb_pkg::*;

  localparam int unsigned Depth = (BUFFER_BYTES < 32) ? BUFFER_BYTES : 32;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(BUFFER_BYTES + 1);

  // input word fields
  req_e             req;
  logic             cs_level;
  logic             mosi_val;
  logic [SlotW-1:0] slot;
  logic [ByteW-1:0] wdata;
  logic             clear_ready;
  logic             in_fire;

  assign req         = req_e'(s_axis_tuser_i);
  assign cs_level    = s_axis_tdata_i[0];
  assign mosi_val    = s_axis_tdata_i[1];
  assign slot        = s_axis_tdata_i[6:2];
  assign wdata       = s_axis_tdata_i[14:7];
  assign clear_ready = s_axis_tlast_i;
  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;

  // block state
  logic            active_q, active_d;
  logic [2:0]      bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]      acc_q, acc_d;
  logic            ready_q, ready_d;
  logic            miso_q, miso_d;
  logic [7:0]      rx_mem_q [Depth];
  logic [7:0]      tx_mem_q [Depth];

  logic            busy;
  logic            cnt_in_mem;
  logic            slot_ok;
  logic [7:0]      tx_byte;
  logic [7:0]      acc_shift;
  logic            rx_we, tx_we;
  result_t         res;

  assign busy       = active_q && (32'(byte_cnt_q) < BUFFER_BYTES);
  assign cnt_in_mem = 32'(byte_cnt_q) < Depth;
  assign slot_ok    = 32'(slot) < BUFFER_BYTES;
  assign tx_byte    = cnt_in_mem ? tx_mem_q[byte_cnt_q[IdxW-1:0]] : 8'h00;
  assign acc_shift  = {acc_q[6:0], mosi_val};

  // per-word state update and result
  always_comb begin
    active_d      = active_q;
    bit_cnt_d     = bit_cnt_q;
    byte_cnt_d    = byte_cnt_q;
    acc_d         = acc_q;
    ready_d       = ready_q;
    miso_d        = miso_q;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    res           = '0;
    case (req)
      REQ_CS: begin
        if (!cs_level) begin
          active_d   = 1'b1;
          bit_cnt_d  = '0;
          byte_cnt_d = '0;
          acc_d      = '0;
        end else if (active_q) begin
          active_d = 1'b0;
          ready_d  = 1'b1;
        end
      end
      REQ_EDGE: begin
        if (busy) begin
          acc_d  = acc_shift;
          miso_d = tx_byte[3'(LastBit - bit_cnt_q)];
          if (bit_cnt_q == LastBit) begin
            rx_we         = cnt_in_mem;
            res.byte_done = 1'b1;
            res.rx_byte   = acc_shift;
            res.byte_pos  = SlotW'(byte_cnt_q);
            acc_d         = '0;
            bit_cnt_d     = '0;
            byte_cnt_d    = byte_cnt_q + 1'b1;
            if (32'(byte_cnt_d) >= BUFFER_BYTES) begin
              ready_d = 1'b1;
            end
          end else begin
            bit_cnt_d = bit_cnt_q + 3'd1;
          end
        end
      end
      REQ_WRITE: begin
        tx_we = slot_ok;
      end
      REQ_READ: begin
        if (ready_q) begin
          if (slot_ok) begin
            res.read_data = rx_mem_q[slot[IdxW-1:0]];
          end
          if (clear_ready) begin
            ready_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    res.miso_val   = miso_d;
    res.busy_res   = active_d && (32'(byte_cnt_d) < BUFFER_BYTES);
    res.data_ready = ready_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      bit_cnt_q  <= '0;
      byte_cnt_q <= '0;
      acc_q      <= '0;
      ready_q    <= 1'b0;
      miso_q     <= 1'b0;
    end else if (in_fire) begin
      active_q   <= active_d;
      bit_cnt_q  <= bit_cnt_d;
      byte_cnt_q <= byte_cnt_d;
      acc_q      <= acc_d;
      ready_q    <= ready_d;
      miso_q     <= miso_d;
    end
  end

  // byte stores, loaded with their power-up contents at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < Depth; i++) begin
        rx_mem_q[i] <= 8'h00;
        tx_mem_q[i] <= tx_init(i);
      end
    end else if (in_fire) begin
      if (rx_we) begin
        rx_mem_q[byte_cnt_q[IdxW-1:0]] <= acc_shift;
      end
      if (tx_we) begin
        tx_mem_q[slot[IdxW-1:0]] <= wdata;
      end
    end
  end

  // output register
  ssbb_obuf u_obuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (in_fire),
    .res_i           (res),
    .ready_o         (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // byte counter never passes BUFFER_BYTES
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(byte_cnt_q) <= BUFFER_BYTES)
    else $error("byte counter beyond store size");

  // eighth bit of a busy transfer reports a finished byte
  a_byte_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req == REQ_EDGE && busy && bit_cnt_q == LastBit |=> m_axis_tuser_o)
    else $error("completed byte not flagged");

  // chip select low restarts the transfer
  a_cs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req == REQ_CS && !cs_level
    |=> active_q && bit_cnt_q == '0 && byte_cnt_q == '0 && acc_q == '0)
    else $error("transfer not restarted");

  // reads without data ready return zero
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req == REQ_READ && !ready_q |=> m_axis_tdata_o[23:16] == 8'h00)
    else $error("read data without data ready");

endmodule

[src/ssbb_obuf.sv]
module ssbb_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ssbb_pkg::result_t res_i,
  output logic             ready_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // miso_val[0], rx_byte[8:1], byte_pos[13:9], busy_res[14], data_ready[15],
  // read_data[23:16]
  output logic [23:0]      m_axis_tdata_o,
  // byte_done[0]
  output logic             m_axis_tuser_o
);
  import ssbb_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // take a new word when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = res_q.byte_done;
  assign m_axis_tdata_o  = {res_q.read_data, res_q.data_ready, res_q.busy_res,
                            res_q.byte_pos, res_q.rx_byte, res_q.miso_val};

endmodule

[tb/spi_slave_byte_buffer_core_test.sv]
module spi_slave_byte_buffer_core_test;
  import ssbb_pkg::*;

  localparam int BUF_BYTES   = 32;
  localparam int PHASE_WORDS = 450;
  localparam int STALL_LIMIT = 4000;

  // one request word, as the block sees it
  typedef struct packed {
    req_e       req;
    logic       cs;
    logic       mosi;
    logic [4:0] slot;
    logic [7:0] wdata;
    logic       clr;
  } spi_req_t;

  // one result word: byte_done on top, then the tdata fields from the top down
  typedef struct packed {
    logic       done;
    logic [7:0] rd;
    logic       rdy;
    logic       busy;
    logic [4:0] pos;
    logic [7:0] rxb;
    logic       miso;
  } spi_res_t;

  typedef struct packed {
    spi_req_t req;
    bit       typed;
    spi_res_t want;
  } script_row_t;

  localparam spi_res_t QUIET    = '0;
  localparam spi_res_t SELECTED = '{busy: 1'b1, default: '0};

  // directed opening: idle corners, one byte in, restart, reads
  localparam script_row_t SCRIPT [24] = '{
    '{'{REQ_READ,  1'b0, 1'b0, 5'd0,  8'h00, 1'b1}, 1'b1, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b1, 5'd0,  8'h00, 1'b0}, 1'b1, QUIET},
    '{'{REQ_CS,    1'b1, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b1, QUIET},
    '{'{REQ_WRITE, 1'b0, 1'b0, 5'd0,  8'hff, 1'b0}, 1'b1, QUIET},
    '{'{REQ_WRITE, 1'b0, 1'b0, 5'd31, 8'h00, 1'b0}, 1'b1, QUIET},
    '{'{REQ_WRITE, 1'b0, 1'b0, 5'd1,  8'h00, 1'b0}, 1'b1, QUIET},
    '{'{REQ_CS,    1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b1, SELECTED},
    '{'{REQ_EDGE,  1'b0, 1'b1, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b1, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b1, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b1, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b1, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b1, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_CS,    1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_EDGE,  1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_CS,    1'b1, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_READ,  1'b0, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET},
    '{'{REQ_READ,  1'b0, 1'b0, 5'd31, 8'h00, 1'b1}, 1'b0, QUIET},
    '{'{REQ_READ,  1'b0, 1'b0, 5'd0,  8'h00, 1'b1}, 1'b0, QUIET},
    '{'{REQ_CS,    1'b1, 1'b0, 5'd0,  8'h00, 1'b0}, 1'b0, QUIET}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_valid       = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_tdata       = '0;
  logic [1:0]  s_tuser       = '0;
  logic        s_tlast       = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_tready      = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int words_sent   = 0;
  int mismatches   = 0;
  int stall_cycles = 0;

  spi_res_t pending_results [$];

  // shadow copy of the slave state
  logic       sel_active;
  logic [2:0] bit_idx;
  logic [5:0] bytes_in;
  logic [7:0] acc_byte;
  logic       rx_ready;
  logic       miso_q;
  logic [7:0] rx_mem [BUF_BYTES];
  logic [7:0] tx_mem [BUF_BYTES];

  spi_slave_byte_buffer_core #(
    .BUFFER_BYTES(BUF_BYTES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // apply one request to the shadow state, return the word it should produce
  function automatic spi_res_t spi_predict(input spi_req_t e);
    spi_res_t r;
    r = '0;
    case (e.req)
      REQ_CS: begin
        if (!e.cs) begin
          sel_active = 1'b1;
          bit_idx    = '0;
          bytes_in   = '0;
          acc_byte   = '0;
        end else if (sel_active) begin
          sel_active = 1'b0;
          rx_ready   = 1'b1;
        end
      end
      REQ_EDGE: begin
        if (sel_active && bytes_in < BUF_BYTES) begin
          miso_q   = tx_mem[bytes_in][3'd7 - bit_idx];
          acc_byte = {acc_byte[6:0], e.mosi};
          if (bit_idx == 3'd7) begin
            rx_mem[bytes_in] = acc_byte;
            r.done   = 1'b1;
            r.rxb    = acc_byte;
            r.pos    = bytes_in[4:0];
            acc_byte = '0;
            bit_idx  = '0;
            bytes_in = bytes_in + 6'd1;
            if (bytes_in >= BUF_BYTES) begin
              rx_ready = 1'b1;
            end
          end else begin
            bit_idx = bit_idx + 3'd1;
          end
        end
      end
      REQ_WRITE: begin
        if (e.slot < BUF_BYTES) begin
          tx_mem[e.slot] = e.wdata;
        end
      end
      REQ_READ: begin
        if (rx_ready) begin
          if (e.slot < BUF_BYTES) begin
            r.rd = rx_mem[e.slot];
          end
          if (e.clr) begin
            rx_ready = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    r.miso = miso_q;
    r.busy = sel_active && (bytes_in < BUF_BYTES);
    r.rdy  = rx_ready;
    return r;
  endfunction

  function automatic spi_req_t noise_req();
    spi_req_t w;
    w.req   = req_e'($urandom_range(0, 3));
    w.cs    = 1'($urandom_range(0, 1));
    w.mosi  = 1'($urandom_range(0, 1));
    w.slot  = 5'($urandom_range(0, 31));
    w.wdata = 8'($urandom_range(0, 255));
    w.clr   = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // present one word, hold it until taken, queue what it should produce
  task automatic send_word(input spi_req_t w, input bit typed, input spi_res_t want);
    spi_res_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {1'b0, w.wdata, w.slot, w.mosi, w.cs};
    s_tuser <= w.req;
    s_tlast <= w.clr;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pred = spi_predict(w);
    pending_results.push_back(typed ? want : pred);
    words_sent++;
  endtask

  // mostly whole transfers with random content, some noise and broken ones
  task automatic run_session(input bit force_full);
    spi_req_t w;
    int nbytes;
    int nedges;
    int nrd;
    if (!force_full && $urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(1, 6)) send_word(noise_req(), 1'b0, QUIET);
    end else begin
      repeat ($urandom_range(0, 2)) begin
        w = noise_req();
        w.req = REQ_WRITE;
        send_word(w, 1'b0, QUIET);
      end
      w = noise_req();
      w.req = REQ_CS;
      w.cs = 1'b0;
      send_word(w, 1'b0, QUIET);
      nbytes = (force_full || $urandom_range(0, 39) == 0) ? BUF_BYTES : $urandom_range(1, 4);
      nedges = nbytes * 8 + ((nbytes == BUF_BYTES) ? $urandom_range(1, 4) : 0);
      // ragged end: stop mid-byte
      if ($urandom_range(0, 7) == 0) begin
        nedges = $urandom_range(1, nedges);
      end
      for (int i = 0; i < nedges; i++) begin
        // occasional write or restart inside the transfer
        if ($urandom_range(0, 49) == 0) begin
          w = noise_req();
          w.req = $urandom_range(0, 1) ? REQ_WRITE : REQ_CS;
          w.cs = 1'b0;
          send_word(w, 1'b0, QUIET);
        end
        w = noise_req();
        w.req = REQ_EDGE;
        send_word(w, 1'b0, QUIET);
      end
      if ($urandom_range(0, 9) != 0) begin
        w = noise_req();
        w.req = REQ_CS;
        w.cs = 1'b1;
        send_word(w, 1'b0, QUIET);
      end
      nrd = $urandom_range(0, 3);
      for (int i = 0; i < nrd; i++) begin
        w = noise_req();
        w.req = REQ_READ;
        w.slot = 5'($urandom_range(0, nbytes - 1));
        w.clr = (i == nrd - 1);
        send_word(w, 1'b0, QUIET);
      end
    end
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // result checking and stall count
  always @(posedge clk_i) begin : check_out
    spi_res_t got;
    spi_res_t want;
    if (m_axis_tvalid_o && m_tready) begin
      got = {m_axis_tuser_o, m_axis_tdata_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word %h", got);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch want done=%0d rx=%02h pos=%0d miso=%0d busy=%0d rdy=%0d rd=%02h",
                     want.done, want.rxb, want.pos, want.miso, want.busy, want.rdy, want.rd);
            $display("         got  done=%0d rx=%02h pos=%0d miso=%0d busy=%0d rdy=%0d rd=%02h",
                     got.done, got.rxb, got.pos, got.miso, got.busy, got.rdy, got.rd);
          end
        end
      end
    end
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    @(posedge rst_ni);
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("FAIL spi_slave_byte_buffer_core");
    $finish;
  end

  initial begin : stimulus
    string greet;
    greet      = "Response from SPI Slave";
    sel_active = 1'b0;
    bit_idx    = '0;
    bytes_in   = '0;
    acc_byte   = '0;
    rx_ready   = 1'b0;
    miso_q     = 1'b0;
    for (int i = 0; i < BUF_BYTES; i++) begin
      rx_mem[i] = 8'h00;
      tx_mem[i] = (i < greet.len()) ? greet[i] : 8'h00;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 19;
          snk_idle_pct = 74;
        end
        1: begin
          src_idle_pct = 74;
          snk_idle_pct = 19;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        foreach (SCRIPT[i]) begin
          send_word(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].want);
        end
        // fill the whole receive store, then edges past the end
        run_session(1'b1);
      end
      while (words_sent < (ph + 1) * PHASE_WORDS) run_session(1'b0);
      // hold off until the receiver has drained everything
      if (ph == 0) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
    end

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS spi_slave_byte_buffer_core");
    end else begin
      $display("FAIL spi_slave_byte_buffer_core");
    end
    $finish;
  end

endmodule
